/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file lbp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LBP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LBP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbp assertion failed");

`endif

/* rtl/core/lbp_pkg.sv */
`default_nettype none
package lbp_pkg;

    // default parameter values
    localparam int MAX_BEAMS_DEF     = 4096;
    localparam int CORDIC_STAGES_DEF = 16;

    // field widths
    localparam int RANGE_W = 16;
    localparam int BEAM_W  = 12;
    localparam int ANGLE_W = 16;
    localparam int POINT_W = 18;
    localparam int CFG_W   = 16;

    // internal datapath widths
    localparam int X_W   = 35;   // cordic x/y, signed, holds gain-scaled range
    localparam int Z_W   = 33;   // residual angle, 2^-32 circle units, signed
    localparam int SUM_W = 21;   // rounded coordinate plus offset
    localparam int BEAM_LIMIT_W = 17;

    // cordic gain folded into the start vector, q16
    localparam logic [RANGE_W-1:0] GAIN_Q16 = 16'd39797;

    localparam logic signed [POINT_W-1:0] SAT_MAX = 18'sd131071;
    localparam logic signed [POINT_W-1:0] SAT_MIN = -18'sd131072;

    // register map
    typedef enum logic [2:0] {
        REG_ANGLE_START = 3'd0,
        REG_ANGLE_STEP  = 3'd1,
        REG_RANGE_LIMIT = 3'd2,
        REG_MOUNT_X     = 3'd3,
        REG_MOUNT_Y     = 3'd4,
        REG_MOUNT_YAW   = 3'd5,
        REG_INVERTED    = 3'd6
    } reg_index_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0]        angle_start;
        logic [CFG_W-1:0]        angle_step;
        logic [CFG_W-1:0]        range_limit;
        logic signed [CFG_W-1:0] mount_x;
        logic signed [CFG_W-1:0] mount_y;
        logic [CFG_W-1:0]        mount_yaw;
        logic                    inverted;
    } cfg_t;

    // payload handed from cell to cell
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  flip;
        logic [BEAM_W-1:0]     beam;
    } cell_data_t;

    // atan(2^-i) in 2^-32 circle units
    function automatic logic [31:0] atan_value(input int idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'h20000000;
            1:       val = 32'h12E4051E;
            2:       val = 32'h09FB385B;
            3:       val = 32'h051111D4;
            4:       val = 32'h028B0D43;
            5:       val = 32'h0145D7E1;
            6:       val = 32'h00A2F61E;
            7:       val = 32'h00517C55;
            8:       val = 32'h0028BE53;
            9:       val = 32'h00145F2F;
            10:      val = 32'h000A2F98;
            11:      val = 32'h000517CC;
            12:      val = 32'h00028BE6;
            13:      val = 32'h000145F3;
            14:      val = 32'h0000A2FA;
            15:      val = 32'h0000517D;
            16:      val = 32'h000028BE;
            17:      val = 32'h0000145F;
            18:      val = 32'h00000A30;
            19:      val = 32'h00000518;
            20:      val = 32'h0000028C;
            21:      val = 32'h00000146;
            22:      val = 32'h000000A3;
            23:      val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/lbp_cordic_cell.sv */
`default_nettype none
module lbp_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_valid,
    input  lbp_pkg::cell_data_t in_data,
    output logic                out_valid,
    output lbp_pkg::cell_data_t out_data
);
    import lbp_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = $signed({1'b0, atan_value(IDX)});

    logic                  valid_reg;
    cell_data_t            data_reg;
    cell_data_t            data_next;
    logic signed [X_W-1:0] dx;
    logic signed [X_W-1:0] dy;

    // one micro-rotation, direction from the sign of the residual angle
    always_comb
    begin
        dx        = in_data.y >>> IDX;
        dy        = in_data.x >>> IDX;
        data_next = in_data;
        if (!in_data.z[Z_W-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* rtl/core/lbp_front.sv */
`default_nettype none
module lbp_front #(
    parameter int MAX_BEAMS = lbp_pkg::MAX_BEAMS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       en,
    input  lbp_pkg::cfg_t             cfg,
    input  wire                       in_valid,
    input  wire [lbp_pkg::RANGE_W-1:0] range_mm,
    input  wire [lbp_pkg::BEAM_W-1:0] beam_index,
    input  wire                       range_invalid,
    output logic                      out_valid,
    output lbp_pkg::cell_data_t       out_data
);
    import lbp_pkg::*;

    localparam logic [BEAM_LIMIT_W-1:0] BEAM_LIMIT = BEAM_LIMIT_W'(MAX_BEAMS);
    localparam int PROD_W = BEAM_W + ANGLE_W;
    localparam int X0_W   = 2 * RANGE_W;

    logic                   keep;
    logic [PROD_W-1:0]      prod_full;
    logic [X0_W-1:0]        x0_full;

    logic                   s1_valid_reg;
    logic [ANGLE_W-1:0]     s1_prod_reg;
    logic [X0_W-1:0]        s1_x0_reg;
    logic [BEAM_W-1:0]      s1_beam_reg;

    logic                   s2_valid_reg;
    cell_data_t             s2_data_reg;
    cell_data_t             s2_data_next;

    logic [ANGLE_W-1:0]     ang_base;
    logic [ANGLE_W-1:0]     ang_dir;
    logic [ANGLE_W-1:0]     ang_total;
    logic signed [ANGLE_W:0] t_raw;
    logic signed [ANGLE_W:0] t_fold;
    logic                   flip;

    // drop filter and the two products
    assign keep = !range_invalid && (range_mm <= cfg.range_limit)
                  && ({{(BEAM_LIMIT_W-BEAM_W){1'b0}}, beam_index} < BEAM_LIMIT);
    assign prod_full = PROD_W'(beam_index) * PROD_W'(cfg.angle_step);
    assign x0_full   = X0_W'(range_mm) * X0_W'(GAIN_Q16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid && keep;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            s1_prod_reg <= prod_full[ANGLE_W-1:0];
            s1_x0_reg   <= x0_full;
            s1_beam_reg <= beam_index;
        end
    end

    // total angle, folded into the right half plane
    always_comb
    begin
        ang_base  = cfg.angle_start + s1_prod_reg;
        ang_dir   = cfg.inverted ? (ANGLE_W'(0) - ang_base) : ang_base;
        ang_total = ang_dir + cfg.mount_yaw;
        t_raw     = $signed({ang_total[ANGLE_W-1], ang_total});
        flip      = 1'b0;
        t_fold    = t_raw;
        if (t_raw > 17'sd16384)
        begin
            t_fold = t_raw - 17'sd32768;
            flip   = 1'b1;
        end
        else if (t_raw < -17'sd16384)
        begin
            t_fold = t_raw + 17'sd32768;
            flip   = 1'b1;
        end
        s2_data_next.x    = $signed({{(X_W-X0_W){1'b0}}, s1_x0_reg});
        s2_data_next.y    = '0;
        s2_data_next.z    = $signed({t_fold, 16'd0});
        s2_data_next.flip = flip;
        s2_data_next.beam = s1_beam_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
            s2_data_reg <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule
`default_nettype wire

/* rtl/core/lbp_post.sv */
`default_nettype none
module lbp_post (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        en,
    input  lbp_pkg::cfg_t              cfg,
    input  wire                        in_valid,
    input  lbp_pkg::cell_data_t        in_data,
    output logic                       out_valid,
    output logic [lbp_pkg::POINT_W-1:0] point_x_mm,
    output logic [lbp_pkg::POINT_W-1:0] point_y_mm,
    output logic [lbp_pkg::BEAM_W-1:0] point_beam
);
    import lbp_pkg::*;

    localparam int RND_W = X_W - 15;

    function automatic logic [POINT_W-1:0] finish(
        input logic signed [X_W-1:0] v,
        input logic                  neg,
        input logic signed [CFG_W-1:0] offset
    );
        logic signed [X_W:0]     biased;
        logic signed [RND_W-1:0] rounded;
        logic signed [SUM_W-1:0] wide;
        logic signed [SUM_W-1:0] sum;
        logic [POINT_W-1:0]      res;
        biased  = $signed({v[X_W-1], v}) + $signed((X_W+1)'(32768));
        rounded = biased[X_W:16];
        wide    = SUM_W'(rounded);
        if (neg)
            wide = -wide;
        sum = wide + SUM_W'(offset);
        if (sum > SUM_W'(SAT_MAX))
            res = SAT_MAX;
        else if (sum < SUM_W'(SAT_MIN))
            res = SAT_MIN;
        else
            res = sum[POINT_W-1:0];
        return res;
    endfunction

    logic               valid_reg;
    logic [POINT_W-1:0] x_reg;
    logic [POINT_W-1:0] y_reg;
    logic [BEAM_W-1:0]  beam_reg;
    logic [POINT_W-1:0] x_next;
    logic [POINT_W-1:0] y_next;

    // round, undo the fold, add mount offset, saturate
    assign x_next = finish(in_data.x, in_data.flip, cfg.mount_x);
    assign y_next = finish(in_data.y, in_data.flip, cfg.mount_y);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            beam_reg <= in_data.beam;
        end
    end

    assign out_valid  = valid_reg;
    assign point_x_mm = x_reg;
    assign point_y_mm = y_reg;
    assign point_beam = beam_reg;

endmodule
`default_nettype wire

/* rtl/core/lidar_beam_projection_unit.sv */
// path: front stages s1 and s2, the CORDIC cell registers, then the post output register
// throughput: one item per cycle unless the output stalls; all stages advance together
// a stalled output holds the whole cell chain and raises in_stall; dropped beams leave a bubble
// reset: asynchronous, active low; clears all valid bits and sets the registers to defaults
`default_nettype none
module lidar_beam_projection_unit #(
    parameter int MAX_BEAMS     = lbp_pkg::MAX_BEAMS_DEF,
    parameter int CORDIC_STAGES = lbp_pkg::CORDIC_STAGES_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [4:0]                   paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire [lbp_pkg::RANGE_W-1:0]  range_mm,
    input  wire [lbp_pkg::BEAM_W-1:0]   beam_index,
    input  wire                         range_invalid,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [lbp_pkg::POINT_W-1:0] point_x_mm,
    output logic [lbp_pkg::POINT_W-1:0] point_y_mm,
    output logic [lbp_pkg::BEAM_W-1:0]  point_beam
);
    import lbp_pkg::*;

    logic [CFG_W-1:0] angle_start_reg;
    logic [CFG_W-1:0] angle_step_reg;
    logic [CFG_W-1:0] range_limit_reg;
    logic [CFG_W-1:0] mount_x_reg;
    logic [CFG_W-1:0] mount_y_reg;
    logic [CFG_W-1:0] mount_yaw_reg;
    logic             inverted_reg;
    cfg_t             cfg;
    reg_index_t       reg_sel;
    logic             wr_en;
    logic             en;

    logic             chain_valid [CORDIC_STAGES+1];
    cell_data_t       chain_data  [CORDIC_STAGES+1];

    // configuration port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
            range_limit_reg <= '1;
            mount_x_reg     <= '0;
            mount_y_reg     <= '0;
            mount_yaw_reg   <= '0;
            inverted_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ANGLE_START: angle_start_reg <= pwdata[CFG_W-1:0];
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata[CFG_W-1:0];
                REG_RANGE_LIMIT: range_limit_reg <= pwdata[CFG_W-1:0];
                REG_MOUNT_X:     mount_x_reg     <= pwdata[CFG_W-1:0];
                REG_MOUNT_Y:     mount_y_reg     <= pwdata[CFG_W-1:0];
                REG_MOUNT_YAW:   mount_yaw_reg   <= pwdata[CFG_W-1:0];
                REG_INVERTED:    inverted_reg    <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_sel)
            REG_ANGLE_START: prdata = {16'd0, angle_start_reg};
            REG_ANGLE_STEP:  prdata = {16'd0, angle_step_reg};
            REG_RANGE_LIMIT: prdata = {16'd0, range_limit_reg};
            REG_MOUNT_X:     prdata = {16'd0, mount_x_reg};
            REG_MOUNT_Y:     prdata = {16'd0, mount_y_reg};
            REG_MOUNT_YAW:   prdata = {16'd0, mount_yaw_reg};
            REG_INVERTED:    prdata = {31'd0, inverted_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.angle_start = angle_start_reg;
    assign cfg.angle_step  = angle_step_reg;
    assign cfg.range_limit = range_limit_reg;
    assign cfg.mount_x     = $signed(mount_x_reg);
    assign cfg.mount_y     = $signed(mount_y_reg);
    assign cfg.mount_yaw   = mount_yaw_reg;
    assign cfg.inverted    = inverted_reg;

    // whole chain moves unless the output item is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // angle and start vector
    lbp_front #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .range_mm      (range_mm),
        .beam_index    (beam_index),
        .range_invalid (range_invalid),
        .out_valid     (chain_valid[0]),
        .out_data      (chain_data[0])
    );

    // cordic cell chain
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        lbp_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // rounding, offset and output register
    lbp_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg),
        .in_valid   (chain_valid[CORDIC_STAGES]),
        .in_data    (chain_data[CORDIC_STAGES]),
        .out_valid  (out_valid),
        .point_x_mm (point_x_mm),
        .point_y_mm (point_y_mm),
        .point_beam (point_beam)
    );

endmodule
`default_nettype wire

/* rtl/core/lbp_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module lbp_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_stall,
    input wire                         out_valid,
    input wire                         out_stall,
    input wire [lbp_pkg::POINT_W-1:0]  point_x_mm,
    input wire [lbp_pkg::POINT_W-1:0]  point_y_mm,
    input wire [lbp_pkg::BEAM_W-1:0]   point_beam
);

    // a held output item stays offered
    `LBP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

    // a held output item does not change
    `LBP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(point_x_mm) && $stable(point_y_mm) && $stable(point_beam))

    // the input side only stalls behind a held output item
    `LBP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // no item leaves right after reset release
    `LBP_ASSERT_IMP(a_reset_empty, $rose(rst_n), !out_valid)

endmodule

bind lidar_beam_projection_unit lbp_checker u_lbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x_mm (point_x_mm),
    .point_y_mm (point_y_mm),
    .point_beam (point_beam)
);
`default_nettype wire

/* test/lidar_beam_projection_checker.sv */
`default_nettype none
module lidar_beam_projection_checker #(
    parameter int MAX_BEAMS     = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [4:0]                   paddr,
    input  wire [31:0]                  pwdata,
    input  wire                         pready,
    input  wire                         in_valid,
    input  wire                         in_stall,
    input  wire [lbp_pkg::RANGE_W-1:0]  range_mm,
    input  wire [lbp_pkg::BEAM_W-1:0]   beam_index,
    input  wire                         range_invalid,
    input  wire                         out_valid,
    input  wire                         out_stall,
    input  wire [lbp_pkg::POINT_W-1:0]  point_x_mm,
    input  wire [lbp_pkg::POINT_W-1:0]  point_y_mm,
    input  wire [lbp_pkg::BEAM_W-1:0]   point_beam,
    output int                          mismatches,
    output int                          points_due
);
    import lbp_pkg::*;

    localparam longint LENGTH_GAIN = 39797;
    localparam int     ATAN_DEPTH  = 24;
    localparam longint COORD_MAX   = 131071;
    localparam longint COORD_MIN   = -131072;

    typedef struct packed {
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic [BEAM_W-1:0]  beam;
    } point_t;

    // register copy as the datapath sees it
    cfg_t   mount_cfg;
    point_t point_q[$];
    int     fail_count;

    // arctangent of 2^-stage in 2^-32 turn units
    function automatic longint atan_turn(input int stage);
        case (stage)
            0:       return 64'h20000000;
            1:       return 64'h12E4051E;
            2:       return 64'h09FB385B;
            3:       return 64'h051111D4;
            4:       return 64'h028B0D43;
            5:       return 64'h0145D7E1;
            6:       return 64'h00A2F61E;
            7:       return 64'h00517C55;
            8:       return 64'h0028BE53;
            9:       return 64'h00145F2F;
            10:      return 64'h000A2F98;
            11:      return 64'h000517CC;
            12:      return 64'h00028BE6;
            13:      return 64'h000145F3;
            14:      return 64'h0000A2FA;
            15:      return 64'h0000517D;
            16:      return 64'h000028BE;
            17:      return 64'h0000145F;
            18:      return 64'h00000A30;
            19:      return 64'h00000518;
            20:      return 64'h0000028C;
            21:      return 64'h00000146;
            22:      return 64'h000000A3;
            23:      return 64'h00000051;
            default: return 64'h0;
        endcase
    endfunction

    // project one beam into the robot frame, returns 0 when the beam is dropped
    function automatic logic project_beam(input logic [RANGE_W-1:0] rng,
                                          input logic [BEAM_W-1:0] beam,
                                          input logic bad_range,
                                          output point_t pt);
        logic [ANGLE_W-1:0] ang;
        int     turn;
        logic   flip;
        longint x, y, z, dx, dy, rx, ry;
        pt = '0;
        if (bad_range || rng > mount_cfg.range_limit || int'(beam) >= MAX_BEAMS)
            return 1'b0;

        // beam angle, mirrored for an upside-down laser, then mount yaw
        ang = mount_cfg.angle_start + beam * mount_cfg.angle_step;
        if (mount_cfg.inverted)
            ang = 16'd0 - ang;
        ang = ang + mount_cfg.mount_yaw;

        // fold into the right half plane
        turn = int'($signed(ang));
        flip = 1'b0;
        if (turn > 16384)
        begin
            turn = turn - 32768;
            flip = 1'b1;
        end
        else if (turn < -16384)
        begin
            turn = turn + 32768;
            flip = 1'b1;
        end

        // rotation-mode cordic on (range, 0)
        x = longint'(rng) * LENGTH_GAIN;
        y = 0;
        z = longint'(turn) * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_DEPTH; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn(i);
            end
        end

        // round, unfold, offset and clamp
        rx = (x + 32768) >>> 16;
        ry = (y + 32768) >>> 16;
        if (flip)
        begin
            rx = -rx;
            ry = -ry;
        end
        rx = rx + longint'($signed(mount_cfg.mount_x));
        ry = ry + longint'($signed(mount_cfg.mount_y));
        if (rx > COORD_MAX) rx = COORD_MAX;
        else if (rx < COORD_MIN) rx = COORD_MIN;
        if (ry > COORD_MAX) ry = COORD_MAX;
        else if (ry < COORD_MIN) ry = COORD_MIN;
        pt.x    = rx[POINT_W-1:0];
        pt.y    = ry[POINT_W-1:0];
        pt.beam = beam;
        return 1'b1;
    endfunction

    // watch register writes and both item channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        point_t got;
        point_t want;
        if (!rst_n)
        begin
            mount_cfg             = '0;
            mount_cfg.range_limit = '1;
            point_q.delete();
            fail_count = 0;
            mismatches <= 0;
            points_due <= 0;
        end
        else
        begin
            // register write completes in the access cycle
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_ANGLE_START: mount_cfg.angle_start = pwdata[CFG_W-1:0];
                    REG_ANGLE_STEP:  mount_cfg.angle_step  = pwdata[CFG_W-1:0];
                    REG_RANGE_LIMIT: mount_cfg.range_limit = pwdata[CFG_W-1:0];
                    REG_MOUNT_X:     mount_cfg.mount_x     = pwdata[CFG_W-1:0];
                    REG_MOUNT_Y:     mount_cfg.mount_y     = pwdata[CFG_W-1:0];
                    REG_MOUNT_YAW:   mount_cfg.mount_yaw   = pwdata[CFG_W-1:0];
                    REG_INVERTED:    mount_cfg.inverted    = pwdata[0];
                    default:         ;
                endcase
            end

            // compare an accepted point with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.x    = point_x_mm;
                got.y    = point_y_mm;
                got.beam = point_beam;
                if (point_q.size() == 0)
                begin
                    $display("%0t: unexpected point x=%0d y=%0d beam=%0d", $time,
                             $signed(got.x), $signed(got.y), got.beam);
                    fail_count++;
                end
                else
                begin
                    want = point_q.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: point expected x=%0d y=%0d beam=%0d,",
                                  " got x=%0d y=%0d beam=%0d"},
                                 $time, $signed(want.x), $signed(want.y), want.beam,
                                 $signed(got.x), $signed(got.y), got.beam);
                        fail_count++;
                    end
                end
            end

            // predict the point of an accepted beam
            if (in_valid && !in_stall)
            begin
                if (project_beam(range_mm, beam_index, range_invalid, want))
                    point_q = {point_q, want};
            end

            mismatches <= fail_count;
            points_due <= point_q.size();
        end
    end

endmodule
`default_nettype wire

/* test/lidar_beam_projection_unit_tb.sv */
`default_nettype none
module lidar_beam_projection_unit_tb;
    import lbp_pkg::*;

    localparam int MAX_BEAMS      = 4096;
    localparam int CORDIC_STAGES  = 16;
    localparam int LATENCY        = CORDIC_STAGES + 3;
    localparam int SETTLE         = 2 * LATENCY + 10;
    localparam int HOLD_CYCLES    = 250;
    localparam int RANDOM_PHASES  = 8;
    localparam int BEAMS_PER_PHASE = 75;
    localparam int TIMEOUT_CYCLES = 200000;
    // address slot past the last register
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [4:0]           paddr         = '0;
    logic [31:0]          pwdata        = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [RANGE_W-1:0]   range_mm      = '0;
    logic [BEAM_W-1:0]    beam_index    = '0;
    logic                 range_invalid = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [POINT_W-1:0]   point_x_mm;
    logic [POINT_W-1:0]   point_y_mm;
    logic [BEAM_W-1:0]    point_beam;

    int                   mismatches;
    int                   points_due;

    // shared between stimulus and sink
    bit                   no_gaps  = 1'b0;
    bit                   hold_req = 1'b0;
    logic [RANGE_W-1:0]   cur_range_limit = '1;
    int                   beams_sent    = 0;
    int                   invalid_sent  = 0;
    int                   settings_used = 0;

    lidar_beam_projection_unit #(
        .MAX_BEAMS     (MAX_BEAMS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .range_mm      (range_mm),
        .beam_index    (beam_index),
        .range_invalid (range_invalid),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .point_x_mm    (point_x_mm),
        .point_y_mm    (point_y_mm),
        .point_beam    (point_beam)
    );

    lidar_beam_projection_checker #(
        .MAX_BEAMS     (MAX_BEAMS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .range_mm      (range_mm),
        .beam_index    (beam_index),
        .range_invalid (range_invalid),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .point_x_mm    (point_x_mm),
        .point_y_mm    (point_y_mm),
        .point_beam    (point_beam),
        .mismatches    (mismatches),
        .points_due    (points_due)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // setup and access cycle, upper data bits are don't-care
    task automatic apb_write(input logic [2:0] idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering beams and let the pipeline run dry
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (points_due != 0 || hold_req)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // full register set, written while idle
    task automatic program_mount(input logic [15:0] start, input logic [15:0] step,
                                 input logic [15:0] max_rng, input logic [15:0] mx,
                                 input logic [15:0] my, input logic [15:0] yaw,
                                 input logic inv);
        wait_idle();
        apb_write(REG_ANGLE_START, start);
        apb_write(REG_ANGLE_STEP, step);
        apb_write(REG_RANGE_LIMIT, max_rng);
        apb_write(REG_MOUNT_X, mx);
        apb_write(REG_MOUNT_Y, my);
        apb_write(REG_MOUNT_YAW, yaw);
        apb_write(REG_INVERTED, {15'd0, inv});
        cur_range_limit = max_rng;
        settings_used++;
    endtask

    // offer one beam after a random gap and wait until it is taken
    task automatic send_beam(input logic [RANGE_W-1:0] rng, input logic [BEAM_W-1:0] beam,
                             input logic bad_range);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        range_mm      <= rng;
        beam_index    <= beam;
        range_invalid <= bad_range;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beams_sent++;
        if (bad_range)
            invalid_sent++;
    endtask

    // point sink: random stalls per item, plus one long hold on request
    initial
    begin : sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // beam stimulus and verdict
    initial
    begin : stimulus
        int                 pick;
        logic [RANGE_W-1:0] rng;
        logic [BEAM_W-1:0]  next_beam;
        logic [BEAM_W-1:0]  beam;
        logic               bad_range;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: zero angle, full range
        send_beam(16'd0, 12'd0, 1'b0);
        send_beam(16'hFFFF, 12'hFFF, 1'b0);
        send_beam(16'd1234, 12'd7, 1'b1);
        send_beam(16'hFFFF, 12'd0, 1'b1);

        // quarter turn edge from above, range limit, unused register slot
        program_mount(16'h4000, 16'd1, 16'd5000, 16'h7FFF, 16'h8000, 16'd0, 1'b0);
        apb_write(REG_SPARE, 16'hFFFF);
        send_beam(16'd5000, 12'd0, 1'b0);
        send_beam(16'd5001, 12'd1, 1'b0);
        send_beam(16'd4999, 12'd1, 1'b0);
        send_beam(16'd3000, 12'hFFF, 1'b0);

        // quarter turn edge from below
        program_mount(16'hC000, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b0);
        send_beam(16'd40000, 12'd0, 1'b0);
        send_beam(16'd40000, 12'd1, 1'b0);
        send_beam(16'd40000, 12'hFFF, 1'b0);

        // inverted mount with half turn yaw, beam zero included
        program_mount(16'd100, 16'd7, 16'hFFFF, -16'sd1000, 16'd2500, 16'h8000, 1'b1);
        send_beam(16'd2000, 12'd0, 1'b0);
        send_beam(16'hFFFF, 12'hFFF, 1'b0);
        send_beam(16'hFFFF, 12'hFFF, 1'b1);
        send_beam(16'd0, 12'd2048, 1'b0);

        // angle wrap and a range just over the limit
        program_mount(16'h7FFF, 16'h7FFF, 16'hFFFE, 16'd0, 16'd0, 16'h4000, 1'b0);
        send_beam(16'hFFFF, 12'd5, 1'b0);
        send_beam(16'hFFFE, 12'hFFF, 1'b0);
        send_beam(16'd12345, 12'd2, 1'b0);

        // random scans over several mount settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: program_mount(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF,
                                 16'hFFFF, 1'b1);
                1: program_mount(16'h7FFF, 16'h8000, 16'd0, 16'h7FFF, 16'h8000,
                                 16'd0, 1'b0);
                default: program_mount(16'($urandom), 16'($urandom),
                                       $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom),
                                       16'($urandom), 16'($urandom), 16'($urandom),
                                       1'($urandom));
            endcase
            no_gaps = (ph % 3 == 2);
            // long output hold while the sender floods the pipe
            if (ph == 3)
            begin
                no_gaps  = 1'b1;
                hold_req = 1'b1;
            end
            next_beam = 12'($urandom);
            repeat (BEAMS_PER_PHASE)
            begin
                pick      = $urandom_range(0, 15);
                bad_range = (pick == 0);
                if (pick <= 2)
                    rng = 16'($urandom);
                else
                    rng = 16'($urandom_range(0, cur_range_limit));
                if (pick == 3)
                    beam = 12'($urandom);
                else
                begin
                    beam      = next_beam;
                    next_beam = next_beam + 12'd1;
                end
                send_beam(rng, beam, bad_range);
            end
        end

        // drain and report
        no_gaps = 1'b0;
        wait_idle();
        $display("covered %0d beams (%0d flagged invalid) over %0d mount settings,",
                 beams_sent, invalid_sent, settings_used);
        $display("including a %0d-cycle output hold that backed up the input",
                 HOLD_CYCLES);
        if (mismatches == 0 && points_due == 0)
            $display("lidar_beam_projection_unit: match");
        else
            $display("lidar_beam_projection_unit: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("timeout with %0d points outstanding", points_due);
        $display("lidar_beam_projection_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
